FILE: hdl/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, codes and record types.
// No dependencies; used by every module in hdl.
package ffha_pkg;

   localparam int MaxBlocks    = 256;
   localparam int IdxW         = $clog2(MaxBlocks);
   localparam int HeaderBytes  = 40;
   localparam int SplitMin     = 64;
   localparam int MinHeap      = 4096;
   localparam int MaxHeap      = 268435456;

   localparam logic [IdxW-1:0] NoLink = '1;

   typedef logic opcode_type;
   localparam opcode_type OpAlloc = 1'b0;
   localparam opcode_type OpFree  = 1'b1;

   typedef logic [2:0] status_type;
   localparam status_type StatOk      = 3'd0;
   localparam status_type StatNothing = 3'd1;
   localparam status_type StatNoSpace = 3'd2;
   localparam status_type StatDouble  = 3'd3;
   localparam status_type StatBad     = 3'd4;

   // one block-table record
   typedef struct packed {
      logic            valid;
      logic            free;
      logic            has_next;
      logic            has_prev;
      logic [27:0]     start;
      logic [27:0]     size;
      logic [IdxW-1:0] next;
      logic [IdxW-1:0] prev;
   } entry_type;

   // memory port commands
   typedef struct packed {
      logic            rd_en;
      logic [IdxW-1:0] rd_addr;
      logic            wr_en;
      logic [IdxW-1:0] wr_addr;
      entry_type       wr_data;
   } mem_cmd_type;

endpackage

FILE: hdl/first_fit_heap_allocator.sv
// Channel | Dir | Contents
// req_    | in  | tuser: opcode; tdata: request_bytes, free_offset
// rsp_    | out | tdata: status, payload_offset, granted_bytes, used_total, totals
// csr_    | in  | wdata: heap_bytes
// One item at a time. An item walks the block list, reading each visited block from the
// table memory, and then writes its updates back.
// After reset or a csr write a clearing pass writes entry 0 as one free block, all
// others invalid; no request is taken then. A stalled result holds in its register.
// Depends on ffha_pkg, ffha_table.
module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [0] opcode
   input  logic         req_tuser,
   // [28:0] request_bytes, [56:29] free_offset
   input  logic [63:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] status, [30:3] payload_offset, [59:31] granted_bytes,
   // [88:60] used_total, [120:89] alloc_total, [152:121] free_total
   output logic [159:0] rsp_tdata,
   input  logic         csr_wen,
   input  logic [28:0]  csr_wdata
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RD, S_EXAM, S_SLOT_RD, S_SLOT_EXAM, S_SPLIT_NX,
      S_WR_CUR, S_F_NXRD, S_F_NX, S_F_NNRD, S_F_NN, S_F_PVRD, S_F_PV,
      S_F_LINKRD, S_F_LINK, S_DONE
   } state_type;

   state_type       state_ff;
   logic [IdxW:0]   clr_ff;
   logic [28:0]     heap_ff;
   opcode_type      op_ff;
   logic [29:0]     size_ff;
   logic [27:0]     off_ff;
   logic [IdxW-1:0] cur_ff, slot_ff, oth_ff;
   logic [IdxW:0]   steps_ff, inuse_ff;
   entry_type       blk_ff;
   entry_type       oth_e_ff;
   logic [28:0]     used_ff;
   logic [31:0]     allocs_ff, frees_ff;
   logic [2:0]      st_ff;
   logic [27:0]     poff_ff;
   logic [28:0]     gr_ff;
   logic            rv_ff;
   mem_cmd_type     cmd;
   entry_type       rd;
   logic [28:0]     hb_sat;
   logic            wen_ff;
   logic [IdxW-1:0] waddr_ff;
   entry_type       wdata_ff;
   // second queued write
   logic            wen2_ff;
   logic [IdxW-1:0] waddr2_ff;
   entry_type       wdata2_ff;

   ffha_table u_table (.clock(clock), .cmd(cmd), .rd_data(rd));

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {7'd0, frees_ff, allocs_ff, used_ff, gr_ff, poff_ff, st_ff};

   always_comb begin
      if (csr_wdata < 29'(MinHeap)) hb_sat = 29'(MinHeap);
      else if (csr_wdata > 29'(MaxHeap)) hb_sat = 29'(MaxHeap);
      else hb_sat = csr_wdata;
   end

   // compute-free entry0 value
   entry_type e0;
   always_comb begin
      e0 = '0;
      e0.valid = 1'b1;
      e0.free  = 1'b1;
      e0.size  = 28'(heap_ff - 29'(HeaderBytes));
   end

   // memory commands from state
   logic [29:0] need;
   assign need = size_ff + 30'(HeaderBytes + SplitMin);

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = clr_ff[IdxW-1:0];
            cmd.wr_data = (clr_ff == '0) ? e0 : '0;
         end
         S_RD, S_F_NXRD, S_F_NNRD, S_F_PVRD, S_F_LINKRD, S_SLOT_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = (state_ff == S_SLOT_RD) ? slot_ff :
                          (state_ff == S_RD) ? cur_ff : oth_ff;
         end
         default: cmd = '0;
      endcase
      // writes issued in sequencing block through wen_ff, waddr_ff and wdata_ff
      if (wen_ff) begin
         cmd.wr_en = 1'b1;
         cmd.wr_addr = waddr_ff;
         cmd.wr_data = wdata_ff;
      end
   end

   // main sequencer
   always_ff @(posedge clock) begin
      logic      wen_in;
      entry_type wdata_in;
      entry_type blk_in;
      wen_in   = 1'b0;
      wdata_in = wdata_ff;
      blk_in   = blk_ff;
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         heap_ff   <= 29'd4194304;
         used_ff   <= '0;
         allocs_ff <= '0;
         frees_ff  <= '0;
         inuse_ff  <= (IdxW+1)'(1);
         rv_ff     <= 1'b0;
         wen2_ff   <= 1'b0;
      end else if (csr_wen) begin
         heap_ff  <= hb_sat;
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         used_ff  <= '0;
         inuse_ff <= (IdxW+1)'(1);
      end else if (wen2_ff) begin
         // drain the queued second write before the next state step
         wen_in   = 1'b1;
         waddr_ff <= waddr2_ff;
         wdata_in = wdata2_ff;
         wen2_ff  <= 1'b0;
      end else begin
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + (IdxW+1)'(1);
               if (clr_ff == (IdxW+1)'(MaxBlocks-1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  op_ff    <= req_tuser;
                  size_ff  <= ({1'b0, req_tdata[28:0]} + 30'd15) & ~30'd15;
                  off_ff   <= req_tdata[56:29];
                  cur_ff   <= '0;
                  steps_ff <= '0;
                  poff_ff  <= '0;
                  gr_ff    <= '0;
                  if (req_tuser == OpAlloc && req_tdata[28:0] == '0) begin
                     st_ff <= StatNothing; state_ff <= S_DONE;
                  end else if (req_tuser == OpFree && req_tdata[56:29] == '0) begin
                     st_ff <= StatNothing; state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: state_ff <= S_EXAM;
            S_EXAM: begin
               blk_in = rd;
               if (op_ff == OpAlloc) begin
                  if (rd.valid && rd.free && {2'b0, rd.size} >= size_ff) begin
                     if ({2'b0, rd.size} >= need && inuse_ff < (IdxW+1)'(MaxBlocks)) begin
                        slot_ff  <= '0;
                        state_ff <= S_SLOT_RD;
                     end else begin
                        state_ff <= S_WR_CUR;
                     end
                  end else if (!rd.has_next ||
                               steps_ff == (IdxW+1)'(MaxBlocks-1)) begin
                     st_ff <= StatNoSpace; state_ff <= S_DONE;
                  end else begin
                     cur_ff   <= rd.next;
                     steps_ff <= steps_ff + (IdxW+1)'(1);
                     state_ff <= S_RD;
                  end
               end else begin
                  if (rd.valid && 28'(rd.start + 28'(HeaderBytes)) == off_ff &&
                      {1'b0, rd.start} + 29'(HeaderBytes) == {1'b0, off_ff}) begin
                     if (rd.free) begin
                        st_ff <= StatDouble; state_ff <= S_DONE;
                     end else begin
                        st_ff    <= StatOk;
                        gr_ff    <= {1'b0, rd.size};
                        frees_ff <= frees_ff + 32'd1;
                        if (used_ff >= {1'b0, rd.size})
                           used_ff <= used_ff - {1'b0, rd.size};
                        blk_in.free = 1'b1;
                        if (rd.has_next) begin
                           oth_ff <= rd.next; state_ff <= S_F_NXRD;
                        end else begin
                           state_ff <= S_F_PVRD;
                        end
                     end
                  end else if (!rd.has_next ||
                               steps_ff == (IdxW+1)'(MaxBlocks-1)) begin
                     st_ff <= StatBad; state_ff <= S_DONE;
                  end else begin
                     cur_ff   <= rd.next;
                     steps_ff <= steps_ff + (IdxW+1)'(1);
                     state_ff <= S_RD;
                  end
               end
            end
            // look for a free table slot, reading and examining one entry at a time
            S_SLOT_RD: state_ff <= S_SLOT_EXAM;
            S_SLOT_EXAM: begin
               if (!rd.valid) begin
                  // new remainder block
                  wen_in = 1'b1;
                  waddr_ff <= slot_ff;
                  wdata_in.valid    = 1'b1;
                  wdata_in.free     = 1'b1;
                  wdata_in.start    = 28'(blk_ff.start + 28'(HeaderBytes) + 28'(size_ff));
                  wdata_in.size     = 28'(blk_ff.size - 28'(size_ff) - 28'(HeaderBytes));
                  wdata_in.next     = blk_ff.next;
                  wdata_in.has_next = blk_ff.has_next;
                  wdata_in.prev     = cur_ff;
                  wdata_in.has_prev = 1'b1;
                  inuse_ff <= inuse_ff + (IdxW+1)'(1);
                  blk_in.next     = slot_ff;
                  blk_in.has_next = 1'b1;
                  blk_in.size     = 28'(size_ff);
                  oth_ff <= blk_ff.next;
                  state_ff <= blk_ff.has_next ? S_SPLIT_NX : S_WR_CUR;
               end else if (slot_ff == NoLink) begin
                  state_ff <= S_WR_CUR;
               end else begin
                  slot_ff <= slot_ff + IdxW'(1); state_ff <= S_SLOT_RD;
               end
            end
            // read next neighbour to relink its prev
            S_SPLIT_NX: begin
               state_ff <= S_F_LINKRD;
               oth_e_ff <= '0;
            end
            S_WR_CUR: begin
               wen_in   = 1'b1;
               waddr_ff <= cur_ff;
               wdata_in = blk_ff;
               wdata_in.free = 1'b0;
               st_ff     <= StatOk;
               used_ff   <= used_ff + {1'b0, blk_ff.size};
               allocs_ff <= allocs_ff + 32'd1;
               poff_ff   <= 28'(blk_ff.start + 28'(HeaderBytes));
               gr_ff     <= {1'b0, blk_ff.size};
               state_ff  <= S_DONE;
            end
            // relink prev of oth_ff to slot_ff after split or merge
            S_F_LINKRD: state_ff <= S_F_LINK;
            S_F_LINK: begin
               wen_in   = 1'b1;
               waddr_ff <= oth_ff;
               wdata_in = rd;
               wdata_in.prev = slot_ff;
               state_ff <= (op_ff == OpFree) ? S_DONE : S_WR_CUR;
            end
            // free: absorb following free blocks
            S_F_NXRD: state_ff <= S_F_NX;
            S_F_NX: begin
               if (rd.free) begin
                  blk_in.size     = 28'(blk_ff.size + 28'(HeaderBytes) + rd.size);
                  blk_in.next     = rd.next;
                  blk_in.has_next = rd.has_next;
                  wen_in   = 1'b1;
                  waddr_ff <= oth_ff;
                  wdata_in = '0;
                  inuse_ff <= inuse_ff - (IdxW+1)'(1);
                  if (rd.has_next) begin
                     oth_ff <= rd.next; state_ff <= S_F_NXRD;
                  end else state_ff <= S_F_PVRD;
               end else begin
                  // relink its prev to blk
                  wen_in   = 1'b1;
                  waddr_ff <= oth_ff;
                  wdata_in = rd;
                  wdata_in.prev = cur_ff;
                  state_ff <= S_F_PVRD;
               end
            end
            S_F_PVRD: begin
               oth_ff <= blk_ff.prev;
               state_ff <= blk_ff.has_prev ? S_F_NNRD : S_F_PV;
            end
            S_F_NNRD: state_ff <= S_F_NN;
            S_F_NN: begin
               oth_e_ff <= rd;
               state_ff <= S_F_PV;
            end
            S_F_PV: begin
               if (blk_ff.has_prev && oth_e_ff.free) begin
                  // merge into previous; fix next's prev
                  wen_in   = 1'b1;
                  waddr_ff <= oth_ff;
                  wdata_in = oth_e_ff;
                  wdata_in.size     = 28'(oth_e_ff.size + 28'(HeaderBytes) + blk_ff.size);
                  wdata_in.next     = blk_ff.next;
                  wdata_in.has_next = blk_ff.has_next;
                  wen2_ff   <= 1'b1;
                  waddr2_ff <= cur_ff;
                  wdata2_ff <= '0;
                  inuse_ff  <= inuse_ff - (IdxW+1)'(1);
                  if (blk_ff.has_next) begin
                     slot_ff <= oth_ff;
                     oth_ff  <= blk_ff.next;
                     state_ff <= S_F_LINKRD;
                  end else state_ff <= S_DONE;
               end else begin
                  wen_in   = 1'b1;
                  waddr_ff <= cur_ff;
                  wdata_in = blk_ff;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               rv_ff    <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      wen_ff   <= wen_in;
      wdata_ff <= wdata_in;
      blk_ff   <= blk_in;
   end

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> state_ff == S_IDLE) else $error("accept while busy");
   a_inuse_bound: assert property (@(posedge clock) disable iff (reset)
      inuse_ff <= (IdxW+1)'(MaxBlocks)) else $error("entry count overflow");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= StatBad) else $error("bad status");
`endif

endmodule

FILE: hdl/ffha_table.sv
// Block-table memory: one synchronous read port, one write port, registered read.
// Depends on ffha_pkg.
module ffha_table
   import ffha_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type cmd,
   output entry_type   rd_data
);

   entry_type mem [MaxBlocks];

   // write and registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data <= mem[cmd.rd_addr];
      end
   end

endmodule
